// ===== rtl/rie_pkg.sv =====
// Shared types and constants of the interleaved rANS encoder.
// Used by every module of the block but rie_ram; depends on nothing else.
`default_nettype none

package rie_pkg;

    localparam int CMD_W       = 2;
    localparam int SYM_W       = 8;
    localparam int LANE_IN_W   = 2;
    localparam int FREQ_W      = 13;
    localparam int START_W     = 12;
    localparam int KIND_W      = 2;
    localparam int STATE_W     = 32;
    localparam int WORD_BITS   = 16;
    localparam int TABLE_DEPTH = 256;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int DIV_CNT_W   = $clog2(STATE_W);

    localparam logic [STATE_W-1:0] STATE_INIT = 32'h0001_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_START  = 2'd1,
        CMD_ENCODE = 2'd2,
        CMD_FLUSH  = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_WORD  = 2'd0,
        KIND_STATE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_WRITE,
        ST_FLUSH
    } fsm_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic tbl_write;
        logic lanes_init;
        logic div_start;
        logic div_step;
        logic write_state;
        logic emit_word;
        logic emit_error;
        logic emit_state;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic freq_zero;
        logic renorm;
        logic div_last;
        logic flush_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/rie_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rie_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/rie_ctrl.sv =====
// Controller state machine of the rANS encoder: sequences load, start,
// encode (check, divide, write back) and flush. Depends on rie_pkg.
`default_nettype none

module rie_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire rie_pkg::cmd_t      command,
    output logic                    s_ready,
    input  wire rie_pkg::dp_status_t status,
    output rie_pkg::ctrl_cmd_t      cmd
);
    import rie_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    case (command)
                        CMD_LOAD:   cmd.tbl_write  = 1'b1;
                        CMD_START:  cmd.lanes_init = 1'b1;
                        CMD_ENCODE: state_next     = ST_CHECK;
                        CMD_FLUSH:  state_next     = ST_FLUSH;
                        default:    state_next     = ST_IDLE;
                    endcase
                end
            end
            ST_CHECK: begin
                if (status.freq_zero) begin
                    if (status.out_free) begin
                        cmd.emit_error = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (!status.renorm || status.out_free) begin
                    // renormalization word goes out as the divide starts
                    cmd.div_start = 1'b1;
                    cmd.emit_word = status.renorm;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write_state = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.emit_state = 1'b1;
                    if (status.flush_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rie_dp.sv =====
// Datapath of the rANS encoder: symbol table, lane states, radix-2
// divider and result register. Depends on rie_pkg and rie_ram.
`default_nettype none

module rie_dp #(
    parameter int LANES        = 4,
    parameter int SCALE_BITS_P = 12
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [rie_pkg::SYM_W-1:0]         symbol,
    input  wire logic [rie_pkg::LANE_IN_W-1:0]     lane,
    input  wire logic [rie_pkg::FREQ_W-1:0]        frequency,
    input  wire logic [rie_pkg::START_W-1:0]       cumulative_start,
    input  wire rie_pkg::ctrl_cmd_t                cmd,
    output rie_pkg::dp_status_t                    status,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output rie_pkg::kind_t                         m_kind,
    output logic [rie_pkg::LANE_IN_W-1:0]          m_lane,
    output logic [rie_pkg::STATE_W-1:0]            m_value,
    output logic                                   m_last
);
    import rie_pkg::*;

    localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int THR_SHIFT = STATE_W - SCALE_BITS_P;
    localparam int THR_W     = STATE_W + FREQ_W;
    localparam int TBL_W     = FREQ_W + START_W;

    // symbol table: frequency and start in one RAM, valid bits in flops
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   valid_q_reg;
    logic [TBL_W-1:0]       tbl_rdata;

    rie_ram #(
        .WIDTH (TBL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_tbl (
        .aclk  (aclk),
        .we    (cmd.tbl_write),
        .waddr (symbol),
        .wdata ({frequency, cumulative_start}),
        .re    (cmd.capture),
        .raddr (symbol),
        .rdata (tbl_rdata)
    );

    logic [FREQ_W-1:0]  freq_rd;
    logic [START_W-1:0] start_rd;

    assign freq_rd  = valid_q_reg ? tbl_rdata[TBL_W-1:START_W] : '0;
    assign start_rd = tbl_rdata[START_W-1:0];

    // lane states
    logic [STATE_W-1:0] lane_state_reg [LANES];
    logic [LANE_W-1:0]  lane_reg;
    logic [LANE_W-1:0]  flush_cnt_reg;
    logic [LANE_W-1:0]  lane_mod;
    logic [STATE_W-1:0] x_cur;
    logic [4:0]         lane_sub;

    // lane modulo LANES by conditional subtraction (the lane field is below 4)
    always_comb begin
        lane_sub = {3'b000, lane};
        for (int i = 0; i < 3; i++) begin
            if (lane_sub >= 5'(LANES)) begin
                lane_sub = lane_sub - 5'(LANES);
            end
        end
    end

    assign lane_mod = lane_sub[LANE_W-1:0];
    assign x_cur    = lane_state_reg[lane_reg];

    // renormalization test against freq << (32 - scale)
    logic [THR_W-1:0]   thr;
    logic [THR_W-1:0]   x_ext;
    logic               renorm;
    logic [STATE_W-1:0] x_div_in;

    assign thr      = THR_W'(freq_rd) << THR_SHIFT;
    assign x_ext    = THR_W'(x_cur);
    assign renorm   = x_ext >= thr;
    assign x_div_in = renorm ? (x_cur >> WORD_BITS) : x_cur;

    // restoring divider, one quotient bit per cycle
    logic [STATE_W-1:0]   quo_reg;
    logic [FREQ_W-1:0]    rem_reg;
    logic [FREQ_W-1:0]    f_reg;
    logic [START_W-1:0]   start_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [FREQ_W:0]      rem_cat;
    logic [FREQ_W:0]      rem_diff;
    logic                 sub_ok;
    logic [FREQ_W-1:0]    rem_next;
    logic [STATE_W-1:0]   quo_next;
    logic [STATE_W-1:0]   new_state;

    assign rem_cat   = {rem_reg, quo_reg[STATE_W-1]};
    assign sub_ok    = rem_cat >= {1'b0, f_reg};
    assign rem_diff  = rem_cat - {1'b0, f_reg};
    assign rem_next  = sub_ok ? rem_diff[FREQ_W-1:0] : rem_cat[FREQ_W-1:0];
    assign quo_next  = {quo_reg[STATE_W-2:0], sub_ok};
    assign new_state = (quo_reg << SCALE_BITS_P) + STATE_W'(rem_reg)
                     + STATE_W'(start_reg);

    // result register
    logic                 m_valid_reg;
    kind_t                m_kind_reg;
    logic [LANE_IN_W-1:0] m_lane_reg;
    logic [STATE_W-1:0]   m_value_reg;
    logic                 m_last_reg;
    logic                 out_free;
    logic                 push;
    logic                 flush_last;
    logic [LANE_W+1:0]    lane_ext;
    logic [LANE_W+1:0]    flush_ext;

    assign out_free   = !m_valid_reg || m_ready;
    assign push       = cmd.emit_word || cmd.emit_error || cmd.emit_state;
    assign flush_last = flush_cnt_reg == LANE_W'(LANES - 1);
    assign lane_ext   = {2'b00, lane_reg};
    assign flush_ext  = {2'b00, flush_cnt_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
            flush_cnt_reg <= '0;
            div_cnt_reg   <= '0;
            for (int i = 0; i < LANES; i++) begin
                lane_state_reg[i] <= STATE_INIT;
            end
        end else begin
            if (cmd.tbl_write) begin
                valid_reg[symbol] <= 1'b1;
            end
            if (cmd.lanes_init) begin
                for (int i = 0; i < LANES; i++) begin
                    lane_state_reg[i] <= STATE_INIT;
                end
            end
            if (cmd.write_state) begin
                lane_state_reg[lane_reg] <= new_state;
            end
            if (cmd.capture) begin
                flush_cnt_reg <= '0;
            end else if (cmd.emit_state) begin
                flush_cnt_reg <= flush_cnt_reg + LANE_W'(1);
            end
            if (cmd.div_start) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            lane_reg    <= lane_mod;
            valid_q_reg <= valid_reg[symbol];
        end
        if (cmd.div_start) begin
            quo_reg   <= x_div_in;
            rem_reg   <= '0;
            f_reg     <= freq_rd;
            start_reg <= start_rd;
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.emit_word) begin
            m_kind_reg  <= KIND_WORD;
            m_lane_reg  <= lane_ext[LANE_IN_W-1:0];
            m_value_reg <= {{(STATE_W-WORD_BITS){1'b0}}, x_cur[WORD_BITS-1:0]};
            m_last_reg  <= 1'b1;
        end else if (cmd.emit_error) begin
            m_kind_reg  <= KIND_ERROR;
            m_lane_reg  <= lane_ext[LANE_IN_W-1:0];
            m_value_reg <= '0;
            m_last_reg  <= 1'b1;
        end else if (cmd.emit_state) begin
            m_kind_reg  <= KIND_STATE;
            m_lane_reg  <= flush_ext[LANE_IN_W-1:0];
            m_value_reg <= lane_state_reg[flush_cnt_reg];
            m_last_reg  <= flush_last;
        end
    end

    assign status.out_free   = out_free;
    assign status.freq_zero  = freq_rd == '0;
    assign status.renorm     = renorm;
    assign status.div_last   = div_cnt_reg == DIV_CNT_W'(STATE_W - 1);
    assign status.flush_last = flush_last;

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_lane  = m_lane_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/interleaved_rans_encoder.sv =====
// Interleaved rANS encoder, top level: input and result stream ports.
// Depends on rie_pkg, rie_ctrl and rie_dp (which holds rie_ram).
//
// Usage:
//   s_axis carries commands; s_axis_tuser selects load table entry, start
//   block, encode symbol or flush states. Load writes frequency and start of
//   one symbol; start sets every lane state to 65536; encode takes one
//   symbol (fed in reverse order) for one lane; flush emits all lane states.
//   m_axis carries results; m_axis_tuser is the kind (renormalization word,
//   final lane state, zero-frequency error), m_axis_tlast marks a single
//   result and the final state of a flush.
// Operation:
//   Encode runs table read and check, the bit-serial divider, then write-back;
//   the check waits while a renormalization word or error cannot enter the
//   output register. A flush emits one lane state after another, waiting while
//   the output register is held. Every result is registered before it appears.
// Reset (aresetn low, synchronous) clears the frequency table to zero and
// sets every lane state to 65536. When m_axis_tready is low, the held result
// stays in the output register; the block keeps accepting transactions until
// it has to produce a further result, and then waits.
`default_nettype none

module interleaved_rans_encoder #(
    parameter int LANES        = 4,
    parameter int SCALE_BITS_P = 12
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // symbol[7:0], lane[9:8], frequency[22:10], cumulative_start[34:23]
    input  wire logic [rie_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // command[1:0]
    input  wire logic [rie_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // out_lane[1:0], value[33:2]
    output logic [rie_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // kind[1:0]
    output logic [rie_pkg::KIND_W-1:0]           m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import rie_pkg::*;

    ctrl_cmd_t            cmd;
    dp_status_t           status;
    kind_t                m_kind;
    logic [LANE_IN_W-1:0] m_lane;
    logic [STATE_W-1:0]   m_value;

    rie_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .command (cmd_t'(s_axis_tuser)),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    rie_dp #(
        .LANES        (LANES),
        .SCALE_BITS_P (SCALE_BITS_P)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .symbol           (s_axis_tdata[7:0]),
        .lane             (s_axis_tdata[9:8]),
        .frequency        (s_axis_tdata[22:10]),
        .cumulative_start (s_axis_tdata[34:23]),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_axis_tvalid),
        .m_ready          (m_axis_tready),
        .m_kind           (m_kind),
        .m_lane           (m_lane),
        .m_value          (m_value),
        .m_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {{(M_TDATA_W - STATE_W - LANE_IN_W){1'b0}}, m_value, m_lane};
    assign m_axis_tuser = m_kind;

endmodule

`default_nettype wire

// ===== rtl/rie_checker.sv =====
// Port-level checks of the rANS encoder result stream, bound to the top.
// Depends on rie_pkg and interleaved_rans_encoder.
`default_nettype none

module rie_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [rie_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input wire logic [rie_pkg::KIND_W-1:0]     m_axis_tuser,
    input wire logic                           m_axis_tlast
);
    import rie_pkg::*;

    // hold a stalled transaction
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == KIND_WORD || m_axis_tuser == KIND_ERROR)
            |-> m_axis_tlast)
        else $error("word or error result without last");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tdata[33:2] == 32'd0)
        else $error("error result with nonzero value");

    a_word_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_WORD |-> m_axis_tdata[33:18] == 16'd0)
        else $error("renormalization word wider than 16 bits");

endmodule

bind interleaved_rans_encoder rie_checker u_rie_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== test/interleaved_rans_encoder_test.sv =====
// Self-checking testbench for the interleaved rANS encoder: drives command transactions,
// predicts renormalization words, final states and errors (directed rows give theirs), and checks each result.
// Depends on rie_pkg and the interleaved_rans_encoder top level.
`default_nettype none

module interleaved_rans_encoder_test;
    import rie_pkg::*;

    localparam int N_LANES        = 4;
    localparam int SCALE_SHIFT    = 12;
    localparam int ITEM_TARGET    = 480;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  sym;
        logic [1:0]  lane;
        logic [12:0] freq;
        logic [11:0] start;
    } enc_cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  lane;
        logic [31:0] value;
        logic        last;
    } enc_out_t;

    typedef struct packed {
        enc_cmd_t    cmd;
        logic        typed;
        kind_t       exp_kind;
        logic [31:0] exp_value;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    // encoder image kept by the testbench
    logic [12:0] freq_tbl [TABLE_DEPTH];
    logic [11:0] start_tbl [TABLE_DEPTH];
    logic [31:0] lane_st [N_LANES];

    enc_out_t step_out [4];
    int       step_n;
    enc_out_t owed_outputs [$];
    dir_row_t dir_rows [$];

    int send_idle_pct;
    int rx_stall_pct;
    int rx_hold_left;
    int idle_cycles;
    int fail_count;
    int items_sent;
    int outputs_seen;
    int words_seen;
    int states_seen;
    int errors_seen;

    interleaved_rans_encoder #(
        .LANES        (N_LANES),
        .SCALE_BITS_P (SCALE_SHIFT)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic enc_cmd_t mk_cmd(input cmd_t cmd, input int sym, input int lane,
                                        input int freq, input int start);
        enc_cmd_t c;
        c.cmd   = cmd;
        c.sym   = sym[7:0];
        c.lane  = lane[1:0];
        c.freq  = freq[12:0];
        c.start = start[11:0];
        return c;
    endfunction

    function automatic void add_out(input kind_t kind, input int lane, input logic [31:0] value,
                                    input logic last);
        step_out[step_n] = '{kind: kind, lane: lane[1:0], value: value, last: last};
        step_n++;
    endfunction

    // Append one result to the list of results still owed by the block.
    function automatic void owe(input enc_out_t e);
        owed_outputs = {owed_outputs, e};
    endfunction

    // Advance the encoder image by one command and collect the outputs it causes.
    function automatic void rans_update(input enc_cmd_t c);
        logic [63:0] f;
        logic [63:0] x;
        int          ln;
        int          i;
        step_n = 0;
        ln = c.lane % N_LANES;
        case (c.cmd)
            CMD_LOAD: begin
                freq_tbl[c.sym]  = c.freq;
                start_tbl[c.sym] = c.start;
            end
            CMD_START: begin
                for (i = 0; i < N_LANES; i++) lane_st[i] = STATE_INIT;
            end
            CMD_ENCODE: begin
                f = 64'(freq_tbl[c.sym]);
                x = 64'(lane_st[ln]);
                if (f == 0) begin
                    add_out(KIND_ERROR, ln, 32'd0, 1'b1);
                end else begin
                    if (x >= (f << (32 - SCALE_SHIFT))) begin
                        add_out(KIND_WORD, ln, {16'd0, x[15:0]}, 1'b1);
                        x = x >> WORD_BITS;
                    end
                    x = ((x / f) << SCALE_SHIFT) + (x % f) + 64'(start_tbl[c.sym]);
                    lane_st[ln] = x[31:0];
                end
            end
            default: begin
                for (i = 0; i < N_LANES; i++)
                    add_out(KIND_STATE, i, lane_st[i], i == N_LANES - 1);
            end
        endcase
    endfunction

    // Offer one command and hold it until the block takes it.
    task automatic send(input enc_cmd_t c, input logic typed = 1'b0,
                        input kind_t exp_kind = KIND_WORD, input logic [31:0] exp_value = 0);
        int i;
        while (roll(send_idle_pct)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, c.start, c.freq, c.lane, c.sym};
        s_axis_tuser  <= c.cmd;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
        rans_update(c);
        if (typed) begin
            if (c.cmd == CMD_FLUSH) begin
                for (i = 0; i < N_LANES; i++)
                    owe('{kind: exp_kind, lane: i[1:0], value: exp_value,
                          last: i == N_LANES - 1});
            end else begin
                owe('{kind: exp_kind, lane: c.lane, value: exp_value, last: 1'b1});
            end
        end else begin
            for (i = 0; i < step_n; i++) owe(step_out[i]);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (owed_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int rand_freq();
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(8191, 4097);
            2:       return 4096;
            3, 4:    return $urandom_range(16, 1);
            default: return $urandom_range(4096, 1);
        endcase
    endfunction

    // Prefer symbols with a loaded frequency; fall back to whatever was drawn last.
    function automatic int pick_coded_sym();
        int s;
        int tries;
        s = $urandom_range(255);
        for (tries = 0; tries < 32 && freq_tbl[s] == 0; tries++) s = $urandom_range(255);
        return s;
    endfunction

    task automatic send_load();
        send(mk_cmd(CMD_LOAD, $urandom_range(255), $urandom_range(3), rand_freq(),
                    $urandom_range(4095)));
    endtask

    task automatic send_encode(input int sym);
        send(mk_cmd(CMD_ENCODE, sym, $urandom_range(3), $urandom_range(8191),
                    $urandom_range(4095)));
    endtask

    task automatic send_flush();
        send(mk_cmd(CMD_FLUSH, $urandom_range(255), $urandom_range(3), $urandom_range(8191),
                    $urandom_range(4095)));
    endtask

    // One coded block: start, a few table updates, a run of mostly encodes mixed with loads, flushes and starts, flush.
    task automatic coded_block(input int n_sym);
        int r;
        send(mk_cmd(CMD_START, $urandom_range(255), $urandom_range(3), $urandom_range(8191),
                    $urandom_range(4095)));
        repeat ($urandom_range(3)) send_load();
        repeat (n_sym) begin
            r = $urandom_range(99);
            if (r < 84)      send_encode(pick_coded_sym());
            else if (r < 90) send_encode($urandom_range(255));
            else if (r < 95) send_load();
            else if (r < 97) send_flush();
            else
                send(mk_cmd(CMD_START, $urandom_range(255), $urandom_range(3),
                            $urandom_range(8191), $urandom_range(4095)));
        end
        send_flush();
    endtask

    function automatic void add_row(input cmd_t cmd, input int sym, input int lane,
                                    input int freq, input int start, input logic typed = 1'b0,
                                    input kind_t exp_kind = KIND_WORD,
                                    input logic [31:0] exp_value = 0);
        dir_row_t row;
        row.cmd       = mk_cmd(cmd, sym, lane, freq, start);
        row.typed     = typed;
        row.exp_kind  = exp_kind;
        row.exp_value = exp_value;
        dir_rows = {dir_rows, row};
    endfunction

    // Result monitor and receiver ready.
    always @(posedge aclk) begin
        enc_out_t got;
        enc_out_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.kind  = kind_t'(m_axis_tuser);
            got.lane  = m_axis_tdata[1:0];
            got.value = m_axis_tdata[33:2];
            got.last  = m_axis_tlast;
            outputs_seen++;
            case (got.kind)
                KIND_WORD:  words_seen++;
                KIND_STATE: states_seen++;
                default:    errors_seen++;
            endcase
            if (owed_outputs.size() == 0) begin
                $error("unexpected result: kind %0d lane %0d value %0h last %0b",
                       got.kind, got.lane, got.value, got.last);
                fail_count++;
            end else begin
                want = owed_outputs.pop_front();
                if (got.kind != want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    fail_count++;
                end
                if (got.lane != want.lane) begin
                    $error("out_lane: expected %0d, got %0d", want.lane, got.lane);
                    fail_count++;
                end
                if (got.value !== want.value) begin
                    $error("value: expected %08h, got %08h", want.value, got.value);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, got.last);
                    fail_count++;
                end
            end
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !roll(rx_stall_pct);
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int i;
        int phase;
        int goal;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        m_axis_tready = 1'b0;
        aresetn       = 1'b0;
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        rx_hold_left  = 0;
        idle_cycles   = 0;
        fail_count    = 0;
        items_sent    = 0;
        outputs_seen  = 0;
        words_seen    = 0;
        states_seen   = 0;
        errors_seen   = 0;
        for (i = 0; i < TABLE_DEPTH; i++) freq_tbl[i] = '0;
        for (i = 0; i < N_LANES; i++) lane_st[i] = STATE_INIT;

        // states right after reset, zero-frequency errors, table extremes
        add_row(CMD_FLUSH,  8'h00, 0, 0, 0, 1'b1, KIND_STATE, STATE_INIT);
        add_row(CMD_ENCODE, 8'h00, 0, 0, 0, 1'b1, KIND_ERROR, 32'd0);
        add_row(CMD_ENCODE, 8'hFF, 3, 8191, 4095, 1'b1, KIND_ERROR, 32'd0);
        add_row(CMD_LOAD,   8'h00, 0, 4096, 0);
        add_row(CMD_LOAD,   8'hFF, 3, 1, 4095);
        add_row(CMD_LOAD,   8'h5A, 2, 8191, 12'hA5A);   // frequency above the scale
        add_row(CMD_LOAD,   8'hA5, 1, 3, 12'h5A5);
        add_row(CMD_ENCODE, 8'h00, 0, 0, 0);
        add_row(CMD_ENCODE, 8'hFF, 1, 0, 0);
        add_row(CMD_ENCODE, 8'hFF, 1, 0, 0);            // crosses the threshold
        add_row(CMD_ENCODE, 8'h5A, 2, 0, 0);
        add_row(CMD_ENCODE, 8'hA5, 3, 0, 0);
        add_row(CMD_ENCODE, 8'hA5, 3, 0, 0);
        add_row(CMD_ENCODE, 8'hA5, 3, 0, 0);
        add_row(CMD_ENCODE, 8'h34, 2, 0, 0, 1'b1, KIND_ERROR, 32'd0);
        add_row(CMD_FLUSH,  8'h00, 0, 0, 0);
        add_row(CMD_START,  8'hFF, 3, 8191, 4095);
        add_row(CMD_FLUSH,  8'hFF, 3, 8191, 4095, 1'b1, KIND_STATE, STATE_INIT);
        add_row(CMD_LOAD,   8'h00, 1, 0, 12'hFFF);      // unload a symbol
        add_row(CMD_ENCODE, 8'h00, 1, 0, 0, 1'b1, KIND_ERROR, 32'd0);
        add_row(CMD_ENCODE, 8'hFF, 0, 0, 0);
        add_row(CMD_FLUSH,  8'h00, 0, 0, 0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[row_idx])
            send(dir_rows[row_idx].cmd, dir_rows[row_idx].typed, dir_rows[row_idx].exp_kind,
                 dir_rows[row_idx].exp_value);
        drain();

        repeat (16) send_load();
        goal = 0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin send_idle_pct = 51; rx_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  rx_stall_pct = 51; end
                default: begin send_idle_pct = 25; rx_stall_pct = 25; end
            endcase
            goal = goal + ITEM_TARGET / 4;
            if (phase == 0) begin
                // hold the result side off while commands keep coming, so the input backs up
                rx_hold_left = LONG_HOLD;
                send_flush();
                repeat (12) send_encode(pick_coded_sym());
                drain();
            end
            while (items_sent < goal) begin
                if ($urandom_range(9) == 0) coded_block($urandom_range(60, 31));
                else                        coded_block($urandom_range(24, 2));
            end
            drain();
        end

        $display("covered %0d commands and %0d results across four idling phases",
                 items_sent, outputs_seen);
        $display("results: %0d renorm words, %0d lane states, %0d zero-frequency errors",
                 words_seen, states_seen, errors_seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
